/* sv/jsu_pkg.sv */
// JSON string unescape: shared types and codes.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package jsu_pkg;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One unit of work for the back end: a code point to encode, a raw byte,
    // or a string end / error marker.
    typedef enum logic [2:0] {
        UOP_NONE = 3'd0,
        UOP_UTF8 = 3'd1,
        UOP_RAW  = 3'd2,
        UOP_END  = 3'd3,
        UOP_ERR  = 3'd4
    } t_uop;

    typedef struct packed {
        t_uop        op;
        logic [20:0] data;
    } t_unit;

    // Everything one input byte produces: at most two units, first in u0.
    typedef struct packed {
        t_unit u0;
        t_unit u1;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/jsu_front.sv */
// JSON string unescape front end: escape and \u parser, surrogate pairing.
// Turns each accepted byte into a command of up to two units; uses jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    output logic               o_cmd_valid,
    output jsu_pkg::t_cmd      o_cmd
);
    import jsu_pkg::*;

    localparam logic [3:0] PH_NORMAL  = 4'd0;
    localparam logic [3:0] PH_ESC     = 4'd1;
    localparam logic [3:0] PH_HEX0    = 4'd2;
    localparam logic [3:0] PH_HEX1    = 4'd3;
    localparam logic [3:0] PH_HEX2    = 4'd4;
    localparam logic [3:0] PH_HEX3    = 4'd5;
    localparam logic [3:0] PH_WANT_BS = 4'd6;
    localparam logic [3:0] PH_WANT_U  = 4'd7;
    localparam logic [3:0] PH_LOHEX0  = 4'd8;
    localparam logic [3:0] PH_LOHEX1  = 4'd9;
    localparam logic [3:0] PH_LOHEX2  = 4'd10;
    localparam logic [3:0] PH_LOHEX3  = 4'd11;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef struct packed {
        logic [3:0] phase;
        t_unit      unit;
    } t_step;

    logic [3:0]  r_phase, n_phase;
    logic [11:0] r_accum, n_accum;
    logic [9:0]  r_held,  n_held;

    logic        hex_ok;
    logic [3:0]  hex_dig;
    logic [15:0] code;
    logic [15:0] held_cp;
    logic [20:0] pair_cp;
    t_step       s_norm, s_esc, s_take;
    t_unit       u_release, u_error;
    t_cmd        cmd;

    function automatic t_unit f_unit(input t_uop op, input logic [20:0] data);
        t_unit u;
        begin
            u.op   = op;
            u.data = data;
            return u;
        end
    endfunction

    function automatic t_step f_normal(input logic [7:0] c);
        t_step s;
        begin
            s.phase = PH_NORMAL;
            s.unit  = f_unit(UOP_RAW, {13'd0, c});
            case (c)
                CH_NUL:   s.unit = f_unit(UOP_ERR, '0);
                CH_QUOTE: s.unit = f_unit(UOP_END, '0);
                CH_BSL: begin
                    s.phase = PH_ESC;
                    s.unit  = f_unit(UOP_NONE, '0);
                end
                default: ;
            endcase
            return s;
        end
    endfunction

    function automatic t_step f_escape(input logic [7:0] c);
        t_step s;
        begin
            s.phase = PH_NORMAL;
            s.unit  = f_unit(UOP_RAW, {13'd0, c});
            case (c)
                CH_NUL: s.unit = f_unit(UOP_ERR, '0);
                CH_U: begin
                    s.phase = PH_HEX0;
                    s.unit  = f_unit(UOP_NONE, '0);
                end
                8'h62:   s.unit = f_unit(UOP_RAW, 21'h08); // b
                8'h66:   s.unit = f_unit(UOP_RAW, 21'h0C); // f
                8'h6E:   s.unit = f_unit(UOP_RAW, 21'h0A); // n
                8'h72:   s.unit = f_unit(UOP_RAW, 21'h0D); // r
                8'h74:   s.unit = f_unit(UOP_RAW, 21'h09); // t
                default: ;
            endcase
            return s;
        end
    endfunction

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_dig = i_byte[3:0];
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_dig = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_dig = 4'(i_byte[3:0] + 4'd9);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign code      = {r_accum, hex_dig};
    assign held_cp   = {6'b110110, r_held};
    // 0x10000 + (high - 0xD800) * 0x400 + (low - 0xDC00)
    assign pair_cp   = 21'h10000 + {1'b0, r_held, code[9:0]};
    assign s_norm    = f_normal(i_byte);
    assign s_esc     = f_escape(i_byte);
    assign u_release = f_unit(UOP_UTF8, {5'd0, held_cp});
    assign u_error   = f_unit(UOP_ERR, '0);

    // complete \u value: hold a high surrogate, encode anything else
    always_comb begin
        if (code >= 16'hD800 && code <= 16'hDBFF) begin
            s_take.phase = PH_WANT_BS;
            s_take.unit  = f_unit(UOP_NONE, '0);
        end else begin
            s_take.phase = PH_NORMAL;
            s_take.unit  = f_unit(UOP_UTF8, {5'd0, code});
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_held  = r_held;
        cmd.u0  = f_unit(UOP_NONE, '0);
        cmd.u1  = f_unit(UOP_NONE, '0);
        case (r_phase)
            PH_NORMAL: begin
                n_phase = s_norm.phase;
                cmd.u0  = s_norm.unit;
            end
            PH_ESC: begin
                n_phase = s_esc.phase;
                cmd.u0  = s_esc.unit;
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (!hex_ok) begin
                    n_phase = PH_NORMAL;
                    cmd.u0  = u_error;
                end else if (r_phase == PH_HEX3) begin
                    n_phase = s_take.phase;
                    n_held  = code[9:0];
                    cmd.u0  = s_take.unit;
                end else begin
                    n_phase = r_phase + 4'd1;
                    n_accum = (r_phase == PH_HEX0) ? {8'd0, hex_dig}
                                                   : {r_accum[7:0], hex_dig};
                end
            end
            PH_WANT_BS: begin
                if (i_byte == CH_BSL) begin
                    n_phase = PH_WANT_U;
                end else begin
                    n_phase = s_norm.phase;
                    cmd.u0  = u_release;
                    cmd.u1  = s_norm.unit;
                end
            end
            PH_WANT_U: begin
                if (i_byte == CH_U) begin
                    n_phase = PH_LOHEX0;
                end else begin
                    n_phase = s_esc.phase;
                    cmd.u0  = u_release;
                    cmd.u1  = s_esc.unit;
                end
            end
            PH_LOHEX0, PH_LOHEX1, PH_LOHEX2, PH_LOHEX3: begin
                if (!hex_ok) begin
                    n_phase = PH_NORMAL;
                    cmd.u0  = u_release;
                    cmd.u1  = u_error;
                end else if (r_phase == PH_LOHEX3) begin
                    if (code >= 16'hDC00 && code <= 16'hDFFF) begin
                        n_phase = PH_NORMAL;
                        cmd.u0  = f_unit(UOP_UTF8, pair_cp);
                    end else begin
                        // not a low surrogate: release, then treat as fresh value
                        n_phase = s_take.phase;
                        n_held  = code[9:0];
                        cmd.u0  = u_release;
                        cmd.u1  = s_take.unit;
                    end
                end else begin
                    n_phase = r_phase + 4'd1;
                    n_accum = (r_phase == PH_LOHEX0) ? {8'd0, hex_dig}
                                                     : {r_accum[7:0], hex_dig};
                end
            end
            default: begin
                n_phase = s_norm.phase;
                cmd.u0  = s_norm.unit;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_take && (cmd.u0.op != UOP_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_accum <= n_accum;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

/* sv/jsu_queue.sv */
// JSON string unescape command queue between front and back end.
// Small register FIFO of jsu_pkg::t_cmd entries.
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire jsu_pkg::t_cmd i_wdata,
    input  wire logic          i_rd,
    output logic               o_full,
    output logic               o_empty,
    output jsu_pkg::t_cmd      o_rdata
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/jsu_back.sv */
// JSON string unescape back end: expands commands into output bytes.
// UTF-8 encoder stepping one byte per cycle, while pop keeps up, into an output register; uses jsu_pkg.
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire jsu_pkg::t_cmd i_q_head,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_result_kind,
    output logic               o_last_of_run
);
    import jsu_pkg::*;

    logic        r_slot;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_kind;
    logic        r_out_last;

    t_unit       unit;
    logic [1:0]  len_m1;
    logic [7:0]  byte_val;
    logic [1:0]  kind;
    logic        unit_done, last_unit, advance;
    logic [20:0] cp;

    assign unit      = r_slot ? i_q_head.u1 : i_q_head.u0;
    assign cp        = unit.data;
    assign last_unit = r_slot || (i_q_head.u1.op == UOP_NONE);

    always_comb begin
        if (cp < 21'h80)         len_m1 = 2'd0;
        else if (cp < 21'h800)   len_m1 = 2'd1;
        else if (cp < 21'h10000) len_m1 = 2'd2;
        else                     len_m1 = 2'd3;
    end

    always_comb begin
        byte_val  = 8'd0;
        kind      = KIND_BYTE;
        unit_done = 1'b1;
        case (unit.op)
            UOP_UTF8: begin
                unit_done = (r_idx == len_m1);
                case (len_m1)
                    2'd0: byte_val = {1'b0, cp[6:0]};
                    2'd1: byte_val = (r_idx == 2'd0) ? {3'b110, cp[10:6]}
                                                     : {2'b10, cp[5:0]};
                    2'd2: begin
                        case (r_idx)
                            2'd0:    byte_val = {4'b1110, cp[15:12]};
                            2'd1:    byte_val = {2'b10, cp[11:6]};
                            default: byte_val = {2'b10, cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (r_idx)
                            2'd0:    byte_val = {5'b11110, cp[20:18]};
                            2'd1:    byte_val = {2'b10, cp[17:12]};
                            2'd2:    byte_val = {2'b10, cp[11:6]};
                            default: byte_val = {2'b10, cp[5:0]};
                        endcase
                    end
                endcase
            end
            UOP_RAW: byte_val = cp[7:0];
            UOP_END: kind     = KIND_END;
            UOP_ERR: kind     = KIND_ERROR;
            default: ;
        endcase
    end

    assign advance = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = advance && unit_done && last_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (unit_done) begin
                    r_idx  <= 2'd0;
                    r_slot <= !last_unit;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= byte_val;
            r_out_kind <= kind;
            r_out_last <= unit_done && last_unit;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_result_kind = r_out_kind;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

/* sv/json_string_unescape_utf8_top.sv */
// JSON string unescape top level: front parser, command queue, UTF-8 back end.
// Instantiates jsu_front, jsu_queue and jsu_back; uses jsu_pkg.
//
//   channel  | handshake        | payload
//   ---------+------------------+-----------------------------------------
//   input    | push / full      | i_in_byte
//   result   | empty / pop      | o_out_byte, o_result_kind, o_last_of_run
//
// One input byte is taken per cycle while full is low; the parser finishes it
// in that cycle and queues at most one command. The back end emits one result
// byte per cycle while pop keeps up, and one input byte can expand to up to 6
// result bytes. The command queue (QUEUE_DEPTH entries) absorbs such bursts;
// full rises only when it fills. Reset is synchronous and empties everything.
`default_nettype none

module json_string_unescape_utf8_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_result_kind,
    output logic            o_last_of_run
);
    import jsu_pkg::*;

    logic q_full, q_empty, q_pop, take, cmd_valid;
    t_cmd cmd, q_head;

    assign take = push && !q_full;
    assign full = q_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd),
        .i_rd    (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_result_kind (o_result_kind),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

/* sv/jsu_chk.sv */
// JSON string unescape port checker and its bind to the top level.
// Watches only top-level ports; uses jsu_pkg result kind codes.
`default_nettype none

module jsu_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_result_kind,
    input wire logic       o_last_of_run
);
    import jsu_pkg::*;

    // reset drains both sides
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result_kind == KIND_BYTE || o_result_kind == KIND_END ||
                    o_result_kind == KIND_ERROR))
        else $error("illegal result kind");

    // end and error markers close a run and carry a zero byte
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result_kind != KIND_BYTE) |-> (o_last_of_run && o_out_byte == 8'd0))
        else $error("marker result malformed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) &&
                              $stable(o_result_kind) && $stable(o_last_of_run)))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8_top jsu_chk u_jsu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_result_kind (o_result_kind),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
